// File: rtl/tds_pkg.sv
package tds_pkg;

  localparam int MaxRows  = 64;
  localparam int FracBits = 24;
  localparam int DataW    = 48;

  typedef struct packed {
    logic signed [DataW-1:0] sub_coeff;
    logic signed [DataW-1:0] diag_coeff;
    logic signed [DataW-1:0] super_coeff;
    logic signed [DataW-1:0] rhs_value;
    logic                    final_row;
  } row_t;

  typedef struct packed {
    logic signed [DataW-1:0] solution_value;
    logic                    last_solution;
    logic                    fault;
  } res_t;

  typedef struct packed {
    logic             fault;
    logic [DataW-1:0] val;
  } fx_t;

  typedef enum logic [1:0] {
    MUL_RATIO_UPPER,
    MUL_RATIO_RHS,
    MUL_UPPER_X
  } mul_sel_e;

  typedef enum logic {
    DIV_SUB_PIV,
    DIV_S_PIV
  } div_sel_e;

  typedef struct packed {
    logic     latch;
    logic     load_first;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     piv_from_mul;
    logic     rhs_from_mul;
    logic     store_row;
    logic     div_go;
    div_sel_e div_sel;
    logic     ratio_from_div;
    logic     cnt_inc;
    logic     set_fault;
    logic     idx_init;
    logic     rd;
    logic     s_from_rhs;
    logic     s_from_mul;
    logic     x_from_div;
    logic     idx_dec;
    logic     idx_inc;
    logic     emit;
    logic     clear;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic fin;
    logic mul_done;
    logic div_done;
    logic idx_zero;
    logic idx_last;
  } sts_t;

  function automatic logic [DataW-1:0] mag(input logic [DataW-1:0] a);
    return a[DataW-1] ? DataW'(-a) : a;
  endfunction

  function automatic fx_t finish(input logic neg, input logic [DataW:0] q, input logic ovf);
    fx_t r;
    logic [DataW:0] limit;
    limit = neg ? {2'b01, {(DataW-1){1'b0}}} : {2'b00, {(DataW-1){1'b1}}};
    r.fault = ovf || (q > limit);
    r.val   = r.fault ? limit[DataW-1:0] : q[DataW-1:0];
    if (neg) begin
      r.val = DataW'(-r.val);
    end
    return r;
  endfunction

  function automatic fx_t fx_sub(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    fx_t r;
    logic [DataW:0] d;
    d = {a[DataW-1], a} - {b[DataW-1], b};
    r.fault = d[DataW] != d[DataW-1];
    if (!r.fault) begin
      r.val = d[DataW-1:0];
    end else if (d[DataW]) begin
      r.val = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r.val = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/tds_mul.sv
module tds_mul #(
  parameter int FRAC_BITS = tds_pkg::FracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [tds_pkg::DataW-1:0]    a_i,
  input  logic [tds_pkg::DataW-1:0]    b_i,
  output logic                         done_o,
  output tds_pkg::fx_t                 res_o
);

  localparam int W = tds_pkg::DataW;
  localparam int H = W / 2;

  logic           active_q, done_q, neg_q;
  logic [1:0]     step_q;
  logic [W-1:0]   ma_q, mb_q;
  logic [2*W-1:0] acc_q;
  logic [H-1:0]   asel, bsel;
  logic [W-1:0]   pp;
  logic [6:0]     shamt;
  logic [W:0]     q;
  logic           ovf;

  assign asel  = step_q[1] ? ma_q[W-1:H] : ma_q[H-1:0];
  assign bsel  = step_q[0] ? mb_q[W-1:H] : mb_q[H-1:0];
  assign pp    = W'(asel) * W'(bsel);
  assign shamt = 7'(H) * (7'(step_q[0]) + 7'(step_q[1]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        active_q <= 1'b1;
        step_q   <= '0;
      end else if (active_q) begin
        if (step_q == 2'd3) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
        step_q <= step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      ma_q  <= tds_pkg::mag(a_i);
      mb_q  <= tds_pkg::mag(b_i);
      neg_q <= a_i[W-1] != b_i[W-1];
      acc_q <= '0;
    end else if (active_q) begin
      acc_q <= acc_q + ((2*W)'(pp) << shamt);
    end
  end

  assign ovf    = (acc_q >> (W - 1 + FRAC_BITS)) != '0;
  assign q      = (W+1)'(W'(acc_q >> FRAC_BITS)) + (W+1)'(acc_q[FRAC_BITS-1]);
  assign res_o  = tds_pkg::finish(neg_q, q, ovf);
  assign done_o = done_q;

endmodule

// File: rtl/tds_div.sv
module tds_div #(
  parameter int FRAC_BITS = tds_pkg::FracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [tds_pkg::DataW-1:0]    a_i,
  input  logic [tds_pkg::DataW-1:0]    b_i,
  output logic                         done_o,
  output tds_pkg::fx_t                 res_o
);

  localparam int W     = tds_pkg::DataW;
  localparam int Steps = W + FRAC_BITS;
  localparam int SW    = $clog2(Steps + 1);

  logic          active_q, done_q, neg_q, zero_q, aneg_q, ovf_q;
  logic [SW-1:0] step_q;
  logic [W-1:0]  dvd_q, mb_q, r_q;
  logic [W:0]    q_q, r_sh, q_sh, q_fin;
  logic          d;

  assign r_sh = {r_q, dvd_q[W-1]};
  assign d    = r_sh >= {1'b0, mb_q};
  assign q_sh = {q_q[W-1:0], d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        active_q <= b_i != '0;
        done_q   <= b_i == '0;
        step_q   <= '0;
      end else if (active_q) begin
        if (step_q == SW'(Steps - 1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
        step_q <= step_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      dvd_q  <= tds_pkg::mag(a_i);
      mb_q   <= tds_pkg::mag(b_i);
      neg_q  <= a_i[W-1] != b_i[W-1];
      aneg_q <= a_i[W-1];
      zero_q <= b_i == '0;
      r_q    <= '0;
      q_q    <= '0;
      ovf_q  <= 1'b0;
    end else if (active_q) begin
      dvd_q <= {dvd_q[W-2:0], 1'b0};
      r_q   <= d ? W'(r_sh - {1'b0, mb_q}) : r_sh[W-1:0];
      if (!ovf_q) begin
        q_q   <= q_sh;
        ovf_q <= q_sh[W];
      end
    end
  end

  assign q_fin = q_q + (W+1)'(!ovf_q && ({r_q, 1'b0} >= {1'b0, mb_q}));

  always_comb begin
    if (zero_q) begin
      res_o.fault = 1'b1;
      res_o.val   = aneg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      res_o = tds_pkg::finish(neg_q, q_fin, ovf_q);
    end
  end

  assign done_o = done_q;

endmodule

// File: rtl/tds_datapath.sv
module tds_datapath #(
  parameter int MAX_ROWS  = tds_pkg::MaxRows,
  parameter int FRAC_BITS = tds_pkg::FracBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tds_pkg::row_t row_i,
  input  tds_pkg::cmd_t cmd_i,
  output tds_pkg::sts_t sts_o,
  output logic          res_valid_o,
  output tds_pkg::res_t res_o
);

  localparam int W  = tds_pkg::DataW;
  localparam int AW = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);

  tds_pkg::row_t row_q;
  logic [W-1:0]  prev_ratio_q, prev_upper_q, prev_rhs_q, piv_q, rr_q, s_q, x_q;
  logic [W-1:0]  pv_rd_q, up_rd_q, rh_rd_q, x_rd_q;
  logic [W-1:0]  pivot_mem [MAX_ROWS];
  logic [W-1:0]  upper_mem [MAX_ROWS];
  logic [W-1:0]  rhs_mem   [MAX_ROWS];
  logic [W-1:0]  x_mem     [MAX_ROWS];
  logic          fault_q, out_vld_q, out_last_q, out_fault_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] idx_q;

  logic [W-1:0]  mul_a, mul_b, div_a, div_b;
  logic          mul_done, div_done;
  tds_pkg::fx_t  mul_res, div_res, sub_piv, sub_rhs, sub_s;

  always_comb begin
    unique case (cmd_i.mul_sel)
      tds_pkg::MUL_RATIO_UPPER: begin mul_a = prev_ratio_q; mul_b = prev_upper_q; end
      tds_pkg::MUL_RATIO_RHS:   begin mul_a = prev_ratio_q; mul_b = prev_rhs_q;   end
      tds_pkg::MUL_UPPER_X:     begin mul_a = up_rd_q;      mul_b = x_q;          end
      default:                  begin mul_a = up_rd_q;      mul_b = x_q;          end
    endcase
    unique case (cmd_i.div_sel)
      tds_pkg::DIV_SUB_PIV: begin div_a = row_q.sub_coeff; div_b = piv_q;   end
      tds_pkg::DIV_S_PIV:   begin div_a = s_q;             div_b = pv_rd_q; end
      default:              begin div_a = s_q;             div_b = pv_rd_q; end
    endcase
  end

  tds_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i, .rst_ni, .go_i(cmd_i.mul_go), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .res_o(mul_res)
  );

  tds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .go_i(cmd_i.div_go), .a_i(div_a), .b_i(div_b),
    .done_o(div_done), .res_o(div_res)
  );

  assign sub_piv = tds_pkg::fx_sub(row_q.diag_coeff, mul_res.val);
  assign sub_rhs = tds_pkg::fx_sub(row_q.rhs_value, mul_res.val);
  assign sub_s   = tds_pkg::fx_sub(rh_rd_q, mul_res.val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q   <= 1'b0;
      cnt_q     <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= cmd_i.emit;
      if (cmd_i.clear) begin
        fault_q <= 1'b0;
        cnt_q   <= '0;
      end else begin
        fault_q <= fault_q | cmd_i.set_fault
                 | (cmd_i.piv_from_mul & (mul_res.fault | sub_piv.fault))
                 | (cmd_i.rhs_from_mul & (mul_res.fault | sub_rhs.fault))
                 | (cmd_i.s_from_mul & (mul_res.fault | sub_s.fault))
                 | ((cmd_i.ratio_from_div | cmd_i.x_from_div) & div_res.fault);
        if (cmd_i.cnt_inc) begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.idx_init) begin
        idx_q <= AW'(cnt_q - CW'(1));
      end else if (cmd_i.idx_dec) begin
        idx_q <= idx_q - AW'(1);
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      row_q <= row_i;
    end
    if (cmd_i.load_first) begin
      piv_q <= row_q.diag_coeff;
      rr_q  <= row_q.rhs_value;
    end
    if (cmd_i.piv_from_mul) begin
      piv_q <= sub_piv.val;
    end
    if (cmd_i.rhs_from_mul) begin
      rr_q <= sub_rhs.val;
    end
    if (cmd_i.store_row) begin
      pivot_mem[cnt_q[AW-1:0]] <= piv_q;
      upper_mem[cnt_q[AW-1:0]] <= row_q.super_coeff;
      rhs_mem[cnt_q[AW-1:0]]   <= rr_q;
      prev_upper_q             <= row_q.super_coeff;
      prev_rhs_q               <= rr_q;
    end
    if (cmd_i.ratio_from_div) begin
      prev_ratio_q <= div_res.val;
    end
    if (cmd_i.rd) begin
      pv_rd_q <= pivot_mem[idx_q];
      up_rd_q <= upper_mem[idx_q];
      rh_rd_q <= rhs_mem[idx_q];
    end
    if (cmd_i.s_from_rhs) begin
      s_q <= rh_rd_q;
    end
    if (cmd_i.s_from_mul) begin
      s_q <= sub_s.val;
    end
    if (cmd_i.x_from_div) begin
      x_q          <= div_res.val;
      x_mem[idx_q] <= div_res.val;
    end
    if (cmd_i.emit) begin
      x_rd_q      <= x_mem[idx_q];
      out_last_q  <= CW'(idx_q) + CW'(1) == cnt_q;
      out_fault_q <= fault_q;
    end
  end

  assign sts_o.full     = cnt_q == CW'(MAX_ROWS);
  assign sts_o.cnt_zero = cnt_q == '0;
  assign sts_o.fin      = row_q.final_row;
  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
  assign sts_o.idx_zero = idx_q == '0;
  assign sts_o.idx_last = CW'(idx_q) + CW'(1) == cnt_q;

  assign res_valid_o          = out_vld_q;
  assign res_o.solution_value = x_rd_q;
  assign res_o.last_solution  = out_last_q;
  assign res_o.fault          = out_fault_q;

endmodule

// File: rtl/tds_ctrl.sv
module tds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tds_pkg::sts_t sts_i,
  output tds_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROW, S_W1, S_W2, S_STORE, S_WD, S_BINIT, S_BREAD,
    S_BSEL, S_BWM, S_BDIV, S_BWD, S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_ROW;
        end
      end
      S_ROW: begin
        if (sts_i.full) begin
          cmd_o.set_fault = 1'b1;
          state_d         = sts_i.fin ? S_BINIT : S_IDLE;
        end else if (sts_i.cnt_zero) begin
          cmd_o.load_first = 1'b1;
          state_d          = S_STORE;
        end else begin
          cmd_o.mul_go  = 1'b1;
          cmd_o.mul_sel = tds_pkg::MUL_RATIO_UPPER;
          state_d       = S_W1;
        end
      end
      S_W1: begin
        if (sts_i.mul_done) begin
          cmd_o.piv_from_mul = 1'b1;
          cmd_o.mul_go       = 1'b1;
          cmd_o.mul_sel      = tds_pkg::MUL_RATIO_RHS;
          state_d            = S_W2;
        end
      end
      S_W2: begin
        cmd_o.mul_sel = tds_pkg::MUL_RATIO_RHS;
        if (sts_i.mul_done) begin
          cmd_o.rhs_from_mul = 1'b1;
          state_d            = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store_row = 1'b1;
        if (sts_i.fin) begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_BINIT;
        end else begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_sel = tds_pkg::DIV_SUB_PIV;
          state_d       = S_WD;
        end
      end
      S_WD: begin
        if (sts_i.div_done) begin
          cmd_o.ratio_from_div = 1'b1;
          cmd_o.cnt_inc        = 1'b1;
          state_d              = S_IDLE;
        end
      end
      S_BINIT: begin
        cmd_o.idx_init = 1'b1;
        state_d        = S_BREAD;
      end
      S_BREAD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_BSEL;
      end
      S_BSEL: begin
        if (sts_i.idx_last) begin
          cmd_o.s_from_rhs = 1'b1;
          state_d          = S_BDIV;
        end else begin
          cmd_o.mul_go  = 1'b1;
          cmd_o.mul_sel = tds_pkg::MUL_UPPER_X;
          state_d       = S_BWM;
        end
      end
      S_BWM: begin
        cmd_o.mul_sel = tds_pkg::MUL_UPPER_X;
        if (sts_i.mul_done) begin
          cmd_o.s_from_mul = 1'b1;
          state_d          = S_BDIV;
        end
      end
      S_BDIV: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = tds_pkg::DIV_S_PIV;
        state_d       = S_BWD;
      end
      S_BWD: begin
        cmd_o.div_sel = tds_pkg::DIV_S_PIV;
        if (sts_i.div_done) begin
          cmd_o.x_from_div = 1'b1;
          if (sts_i.idx_zero) begin
            state_d = S_EMIT;
          end else begin
            cmd_o.idx_dec = 1'b1;
            state_d       = S_BREAD;
          end
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy    <= 1'b0;
    end else begin
      state_q <= state_d;
      busy    <= state_d != S_IDLE;
    end
  end

endmodule

// File: rtl/tridiagonal_system_solver.sv
// a non-final row holds busy while the pivot and rhs are updated (not for the first row
// of a system) and its ratio is divided out; a new row can start as soon as busy is low
// a final row then back-substitutes each stored row with a multiply (but for the last row)
// and a bit-serial division, then gives one result per cycle; rows are taken one at a time
// the divider (one quotient bit a cycle) and the multiplier (4 partial products) set the rate
// reset: async active low, clears row count, fault and control; stores kept; no result stall
module tridiagonal_system_solver #(
  parameter int MAX_ROWS  = tds_pkg::MaxRows,
  parameter int FRAC_BITS = tds_pkg::FracBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tds_pkg::row_t row_i,
  output logic          res_valid_o,
  output tds_pkg::res_t res_o
);

  tds_pkg::cmd_t cmd;
  tds_pkg::sts_t sts;

  tds_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .sts_i(sts), .cmd_o(cmd)
  );

  tds_datapath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .row_i, .cmd_i(cmd), .sts_o(sts), .res_valid_o, .res_o
  );

endmodule

// File: sim/tb_tridiagonal_system_solver.sv
module tb_tridiagonal_system_solver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned Top47 = 64'd1 << 47;
  localparam longint FxMax = longint'(Top47 - 1);
  localparam longint FxMin = -longint'(Top47);
  localparam longint One = 64'sd1 <<< tds_pkg::FracBits;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  tds_pkg::row_t row_i;
  logic res_valid_o;
  tds_pkg::res_t res_o;

  tridiagonal_system_solver uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .row_i(row_i),
    .res_valid_o(res_valid_o),
    .res_o(res_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // solver model state
  longint ratio_m[tds_pkg::MaxRows];
  longint pivot_m[tds_pkg::MaxRows];
  longint upper_m[tds_pkg::MaxRows];
  longint rhs_m[tds_pkg::MaxRows];
  int unsigned rows_held;
  bit sys_fault;
  tds_pkg::res_t solution_q[$];
  int errors;
  bit quiet;

  function automatic longint sx48(logic [tds_pkg::DataW-1:0] v);
    return {{16{v[tds_pkg::DataW-1]}}, v};
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint clamp_sign(bit neg, longint unsigned q, bit ovf);
    longint unsigned limit;
    limit = neg ? Top47 : Top47 - 1;
    if (ovf || q > limit) begin
      sys_fault = 1'b1;
      q = limit;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    longint d;
    d = a - b;
    if (d > FxMax) begin
      sys_fault = 1'b1;
      return FxMax;
    end
    if (d < FxMin) begin
      sys_fault = 1'b1;
      return FxMin;
    end
    return d;
  endfunction

  function automatic longint fx_mult(longint a, longint b);
    bit neg;
    longint unsigned ma, mb, a1, a0, b1, b0, p0, p1, p2, t, hi, lo, q;
    neg = (a < 0) != (b < 0);
    ma = absval(a);
    mb = absval(b);
    a1 = ma >> 24;
    a0 = ma & 64'hFFFFFF;
    b1 = mb >> 24;
    b0 = mb & 64'hFFFFFF;
    p0 = a0 * b0;
    p1 = a1 * b0 + a0 * b1;
    p2 = a1 * b1;
    t = p1 + (p0 >> 24);
    hi = p2 + (t >> 24);
    lo = ((t & 64'hFFFFFF) << 24) | (p0 & 64'hFFFFFF);
    if ((hi >> (tds_pkg::FracBits - 1)) != 0) return clamp_sign(neg, 0, 1'b1);
    q = (hi << (tds_pkg::DataW - tds_pkg::FracBits)) | (lo >> tds_pkg::FracBits);
    q += (lo >> (tds_pkg::FracBits - 1)) & 1;
    return clamp_sign(neg, q, 1'b0);
  endfunction

  function automatic longint fx_quot(longint a, longint b);
    bit neg, ovf;
    longint unsigned ma, mb, r, q, bt, d;
    neg = (a < 0) != (b < 0);
    ma = absval(a);
    mb = absval(b);
    r = 0;
    q = 0;
    ovf = 1'b0;
    if (b == 0) begin
      sys_fault = 1'b1;
      return a < 0 ? FxMin : FxMax;
    end
    for (int k = tds_pkg::DataW + tds_pkg::FracBits - 1; k >= 0; k--) begin
      bt = k >= tds_pkg::FracBits ? (ma >> (k - tds_pkg::FracBits)) & 1 : 0;
      d = 0;
      r = (r << 1) | bt;
      if (r >= mb) begin
        r -= mb;
        d = 1;
      end
      if (!ovf) begin
        q = (q << 1) | d;
        if ((q >> 48) != 0) ovf = 1'b1;
      end
    end
    if (!ovf && (r << 1) >= mb) q += 1;
    return clamp_sign(neg, q, ovf);
  endfunction

  function automatic void back_substitute();
    longint x[tds_pkg::MaxRows];
    tds_pkg::res_t r;
    int n;
    n = rows_held;
    if (n == 0) return;
    x[n-1] = fx_quot(rhs_m[n-1], pivot_m[n-1]);
    for (int i = n - 2; i >= 0; i--) begin
      x[i] = fx_quot(sat_sub(rhs_m[i], fx_mult(upper_m[i], x[i+1])), pivot_m[i]);
    end
    for (int i = 0; i < n; i++) begin
      r.solution_value = x[i][tds_pkg::DataW-1:0];
      r.last_solution = (i == n - 1);
      r.fault = sys_fault;
      solution_q = {solution_q, r};
    end
    rows_held = 0;
    sys_fault = 1'b0;
  endfunction

  function automatic void eliminate_row(tds_pkg::row_t r);
    int unsigned i;
    longint m;
    i = rows_held;
    if (i >= tds_pkg::MaxRows) begin
      sys_fault = 1'b1;
      if (r.final_row) back_substitute();
      return;
    end
    if (i == 0) begin
      pivot_m[0] = sx48(r.diag_coeff);
      rhs_m[0] = sx48(r.rhs_value);
    end else begin
      m = ratio_m[i-1];
      pivot_m[i] = sat_sub(sx48(r.diag_coeff), fx_mult(m, upper_m[i-1]));
      rhs_m[i] = sat_sub(sx48(r.rhs_value), fx_mult(m, rhs_m[i-1]));
    end
    upper_m[i] = sx48(r.super_coeff);
    ratio_m[i] = r.final_row ? 0 : fx_quot(sx48(r.sub_coeff), pivot_m[i]);
    rows_held = i + 1;
    if (r.final_row) back_substitute();
  endfunction

  task automatic send_row(tds_pkg::row_t r);
    start <= 1'b1;
    row_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    eliminate_row(r);
    if (!quiet && $urandom_range(99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [tds_pkg::DataW-1:0] rand48();
    return tds_pkg::DataW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [tds_pkg::DataW-1:0] small_fx();
    return tds_pkg::DataW'(longint'($urandom_range(0, 16 * One)) - 8 * One);
  endfunction

  function automatic tds_pkg::row_t mk_row(longint s, longint d, longint u, longint b, bit f);
    tds_pkg::row_t r;
    r.sub_coeff = s[tds_pkg::DataW-1:0];
    r.diag_coeff = d[tds_pkg::DataW-1:0];
    r.super_coeff = u[tds_pkg::DataW-1:0];
    r.rhs_value = b[tds_pkg::DataW-1:0];
    r.final_row = f;
    return r;
  endfunction

  task automatic test_single_rows();
    send_row(mk_row(0, One, 0, 3 * One, 1'b1));
    send_row(mk_row(0, 0, 0, -One, 1'b1));
    send_row(mk_row(0, 0, 0, 0, 1'b1));
    send_row(mk_row(FxMax, 1, FxMin, FxMax, 1'b1));
    send_row(mk_row(0, -One, 0, FxMin, 1'b1));
    drain();
  endtask

  task automatic test_extremes();
    send_row(mk_row(FxMax, 1, FxMax, FxMax, 1'b0));
    send_row(mk_row(FxMin, FxMin, FxMin, FxMin, 1'b0));
    send_row(mk_row(0, FxMax, 0, FxMin, 1'b1));
    send_row(mk_row(One, 0, One, One, 1'b0));
    send_row(mk_row(One, 4 * One, One, -One, 1'b1));
    drain();
  endtask

  task automatic test_small_systems();
    send_row(mk_row(One, 4 * One, One, 5 * One, 1'b0));
    send_row(mk_row(One, 4 * One, One, 6 * One, 1'b0));
    send_row(mk_row(FxMax, 4 * One, FxMax, 5 * One, 1'b1));
    send_row(mk_row(-One, 2 * One, -One, One, 1'b0));
    send_row(mk_row(-One, 2 * One, -One, 0, 1'b0));
    send_row(mk_row(0, 2 * One, 0, -One, 1'b1));
    send_row(mk_row(rand48(), rand48(), rand48(), rand48(), 1'b0));
    send_row(mk_row(rand48(), rand48(), rand48(), rand48(), 1'b1));
    drain();
  endtask

  task automatic send_system(int n, bit noisy);
    tds_pkg::row_t r;
    for (int i = 0; i < n; i++) begin
      if (noisy) begin
        r = {rand48(), rand48(), rand48(), rand48(), 1'b0};
        if ($urandom_range(9) == 0) r.diag_coeff = '0;
      end else begin
        r.sub_coeff = small_fx();
        r.super_coeff = small_fx();
        r.diag_coeff = tds_pkg::DataW'(longint'($urandom_range(0, 8 * One)) + 17 * One);
        if ($urandom_range(1)) r.diag_coeff = -r.diag_coeff;
        r.rhs_value = $urandom_range(3) == 0 ? rand48() : small_fx();
      end
      r.final_row = (i == n - 1);
      send_row(r);
    end
  endtask

  task automatic test_row_overflow();
    send_system(tds_pkg::MaxRows + 2, 1'b0);
    drain();
    send_system(tds_pkg::MaxRows, 1'b1);
    send_row(mk_row(0, One, 0, One, 1'b0));
    send_row(mk_row(0, One, 0, One, 1'b1));
    drain();
  endtask

  task automatic test_random_systems();
    int sent;
    sent = 0;
    while (sent < 120) begin
      int n;
      n = $urandom_range(1, 8);
      quiet = sent > 30 && sent < 80;
      send_system(n, $urandom_range(3) == 0);
      sent += n;
      if ($urandom_range(19) == 0) drain();
    end
    quiet = 1'b0;
    drain();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (solution_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, res_o);
        errors++;
      end else begin
        tds_pkg::res_t e;
        e = solution_q.pop_front();
        if (res_o.solution_value !== e.solution_value) begin
          $display("%0t: solution_value expected %h actual %h", $realtime,
                   e.solution_value, res_o.solution_value);
          errors++;
        end
        if (res_o.last_solution !== e.last_solution) begin
          $display("%0t: last_solution expected %b actual %b", $realtime,
                   e.last_solution, res_o.last_solution);
          errors++;
        end
        if (res_o.fault !== e.fault) begin
          $display("%0t: fault expected %b actual %b", $realtime, e.fault, res_o.fault);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    errors = 0;
    rows_held = 0;
    sys_fault = 1'b0;
    quiet = 1'b0;
    start = 1'b0;
    row_i = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_rows();
    test_extremes();
    test_small_systems();
    test_row_overflow();
    test_random_systems();
    if (solution_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, solution_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
